@@ hdl/pov_stc_pkg.sv @@
`timescale 1ns / 1ps

package pov_stc_pkg;

  // fixed field widths
  localparam int unsigned LED_COUNT  = 16;
  localparam int unsigned SLICE_W    = 5;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HOLDOFF_W  = 16;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PROD_W     = CNT_W + SCALE_W;

  // default slice count
  localparam int unsigned SLICES_DEF = 32;

  // register reset values
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 16'd200;
  localparam logic [SCALE_W-1:0]   SCALE_RST   = 8'd255;

  // request modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PROD,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_state_e;

endpackage

@@ hdl/pov_stc_div.sv @@
`timescale 1ns / 1ps

module pov_stc_div #(
  parameter int unsigned SLICES = pov_stc_pkg::SLICES_DEF
) (
  input  logic                                                         clk_i,
  input  logic                                                         rst_ni,
  input  logic                                                         start_i,
  input  logic [pov_stc_pkg::PROD_W+$clog2(SLICES+1)-1:0]              num_i,
  input  logic [pov_stc_pkg::CNT_W-1:0]                                period_i,
  output logic                                                         done_o,
  output logic [$clog2(SLICES)-1:0]                                    quot_o
);
  import pov_stc_pkg::*;

  localparam int unsigned QW    = $clog2(SLICES);
  localparam int unsigned NUM_W = PROD_W + $clog2(SLICES + 1);
  localparam int unsigned CW    = $clog2(QW + 1);
  localparam logic [QW-1:0] LAST = QW'(SLICES - 1);

  div_state_e state_q, state_d;

  logic [NUM_W-1:0]    num_q;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [QW-1:0]       lo_q, lo_d;
  logic [QW-1:0]       q_q, q_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [NUM_W-QW-1:0] num_hi;
  logic                over;
  logic [CNT_W:0]      trial;
  logic                fits;

  // quotient reaches 2^QW or more, or zero period: clamp to last slice
  assign num_hi = num_q[NUM_W-1:QW];
  assign over   = (period_i == '0) || (num_hi >= (NUM_W-QW)'(period_i));
  assign trial  = {rem_q, lo_q[QW-1]};
  assign fits   = trial >= {1'b0, period_i};

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE:  if (start_i) state_d = DV_CHECK;
      DV_CHECK: state_d = over ? DV_DONE : DV_RUN;
      DV_RUN:   if (cnt_q == CW'(1)) state_d = DV_DONE;
      DV_DONE:  state_d = DV_IDLE;
      default:  state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    rem_d = rem_q;
    lo_d  = lo_q;
    q_d   = q_q;
    cnt_d = cnt_q;
    case (state_q)
      DV_CHECK: begin
        if (over) begin
          q_d = LAST;
        end else begin
          rem_d = num_q[QW+CNT_W-1:QW];
          lo_d  = num_q[QW-1:0];
          q_d   = '0;
          cnt_d = CW'(QW);
        end
      end
      DV_RUN: begin
        rem_d = fits ? CNT_W'(trial - {1'b0, period_i}) : trial[CNT_W-1:0];
        lo_d  = lo_q << 1;
        q_d   = (q_q << 1) | QW'(fits);
        cnt_d = cnt_q - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && start_i) num_q <= num_i;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    q_q   <= q_d;
  end

  assign done_o = (state_q == DV_DONE);
  assign quot_o = (q_q > LAST) ? LAST : q_q;

endmodule

@@ hdl/pov_slice_timing_controller.sv @@
`timescale 1ns / 1ps

// slice timing for a rotating led display
// input channel (in_valid_i / in_ready_o) takes one request per accept:
//   mode tick advances the saturating elapsed-tick counter, mode edge is a
//   rotation index edge (taken only past the holdoff; it averages the period
//   and clears the counter), mode write loads one column pattern, mode 3 is
//   ignored
// write and ignored requests keep the block idle; the next one can follow
// a tick runs the multiply, product, divide and table read states, then emit
// when its slice changes; the divide skips its run when the range check clamps
// the slice; an accepted edge repeats multiply and product to update the period;
// the slice is found by a restoring divider that resolves one quotient bit per
// cycle after the range check; a result is sent on out_valid_o / out_ready_i only
// when the slice changes; it waits in an output register, so a stalled receiver
// does not block new requests until the next result is due
// config channel (cfg_valid_i / cfg_ready_o) is always ready: index 0 holdoff,
// index 1 time scale, other indexes ignored
// reset: counter and period are one, no slice counts as shown, holdoff 200,
// scale 255; the column table is not cleared
module pov_slice_timing_controller #(
  parameter int unsigned SLICES = pov_stc_pkg::SLICES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pov_stc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pov_stc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [pov_stc_pkg::MODE_W-1:0]        mode_i,
  input  logic [pov_stc_pkg::ADDR_W-1:0]        slice_addr_i,
  input  logic [pov_stc_pkg::LED_COUNT-1:0]     pattern_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pov_stc_pkg::SLICE_W-1:0]       slice_o,
  output logic [pov_stc_pkg::LED_COUNT-1:0]     columns_o
);
  import pov_stc_pkg::*;

  localparam int unsigned QW    = $clog2(SLICES);
  localparam int unsigned NUM_W = PROD_W + $clog2(SLICES + 1);

  ctrl_state_e state_q, state_d;

  // scalar state
  logic [CNT_W-1:0]     elapsed_q, elapsed_d;
  logic [CNT_W-1:0]     period_q, period_d;
  logic [HOLDOFF_W-1:0] holdoff_q, holdoff_d;
  logic [SCALE_W-1:0]   scale_q, scale_d;
  logic [QW-1:0]        shown_q, shown_d;
  logic                 shown_vld_q, shown_vld_d;
  logic                 edge_q, edge_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [QW-1:0]        slice_q, slice_d;

  // output register
  logic                 out_vld_q, out_vld_d;
  logic [SLICE_W-1:0]   out_slice_q, out_slice_d;
  logic [LED_COUNT-1:0] out_col_q, out_col_d;

  // column table
  logic [LED_COUNT-1:0] mem [SLICES];
  logic [LED_COUNT-1:0] rd_q;
  logic                 mem_we, mem_re;
  logic [QW-1:0]        mem_wa, mem_ra;

  logic                 in_acc;
  logic                 out_free;
  logic [QW+ADDR_W-1:0] wa_ext;
  logic                 wa_ok;
  logic [QW+SLICE_W-1:0] slice_ext;
  logic [PROD_W:0]      psum;
  logic [PROD_W-1:0]    phalf;
  logic [NUM_W-1:0]     num;
  logic                 div_start, div_done;
  logic [QW-1:0]        div_quot;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;

  assign wa_ext    = {{QW{1'b0}}, slice_addr_i};
  assign wa_ok     = wa_ext < (QW+ADDR_W)'(SLICES);
  assign slice_ext = {{SLICE_W{1'b0}}, slice_q};

  // new period: mean of old period and elapsed*scale, saturated
  assign psum  = {1'b0, prod_q} + (PROD_W+1)'(period_q);
  assign phalf = psum[PROD_W:1];
  assign num   = NUM_W'(prod_q) * NUM_W'(SLICES);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (mode_i == MODE_TICK || mode_i == MODE_EDGE)) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_PROD;
      ST_PROD: state_d = edge_q ? ST_MUL : ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_READ;
      ST_READ: begin
        if (shown_vld_q && slice_q == shown_q) state_d = ST_IDLE;
        else state_d = ST_EMIT;
      end
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    elapsed_d   = elapsed_q;
    period_d    = period_q;
    holdoff_d   = holdoff_q;
    scale_d     = scale_q;
    shown_d     = shown_q;
    shown_vld_d = shown_vld_q;
    edge_d      = edge_q;
    prod_d      = prod_q;
    slice_d     = slice_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_slice_d = out_slice_q;
    out_col_d   = out_col_q;
    mem_we      = 1'b0;
    mem_wa      = wa_ext[QW-1:0];
    mem_re      = 1'b0;
    mem_ra      = slice_q;
    div_start   = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HOLDOFF: holdoff_d = cfg_data_i[HOLDOFF_W-1:0];
        REG_SCALE:   scale_d   = cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            MODE_TICK: begin
              if (elapsed_q != '1) elapsed_d = elapsed_q + CNT_W'(1);
            end
            MODE_EDGE: begin
              if (elapsed_q > CNT_W'(holdoff_q)) edge_d = 1'b1;
            end
            MODE_WRITE: mem_we = wa_ok;
            default: ;
          endcase
        end
      end
      ST_MUL: prod_d = elapsed_q * PROD_W'(scale_q);
      ST_PROD: begin
        if (edge_q) begin
          period_d  = (|phalf[PROD_W-1:CNT_W]) ? '1 : phalf[CNT_W-1:0];
          elapsed_d = '0;
          edge_d    = 1'b0;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIV: if (div_done) slice_d = div_quot;
      ST_READ: begin
        if (!(shown_vld_q && slice_q == shown_q)) begin
          mem_re      = 1'b1;
          shown_d     = slice_q;
          shown_vld_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_slice_d = slice_ext[SLICE_W-1:0];
          out_col_d   = rd_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= CNT_W'(1);
      period_q    <= CNT_W'(1);
      holdoff_q   <= HOLDOFF_RST;
      scale_q     <= SCALE_RST;
      shown_vld_q <= 1'b0;
      edge_q      <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      period_q    <= period_d;
      holdoff_q   <= holdoff_d;
      scale_q     <= scale_d;
      shown_vld_q <= shown_vld_d;
      edge_q      <= edge_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    slice_q     <= slice_d;
    shown_q     <= shown_d;
    out_slice_q <= out_slice_d;
    out_col_q   <= out_col_d;
  end

  // column table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= pattern_i;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  pov_stc_div #(
    .SLICES (SLICES)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (num),
    .period_i (period_q),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  assign out_valid_o = out_vld_q;
  assign slice_o     = out_slice_q;
  assign columns_o   = out_col_q;

endmodule

@@ hdl/pov_stc_chk.sv @@
`timescale 1ns / 1ps

module pov_stc_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic [pov_stc_pkg::MODE_W-1:0]        mode_i,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic [pov_stc_pkg::SLICE_W-1:0]       slice_o,
  input logic [pov_stc_pkg::LED_COUNT-1:0]     columns_o
);
  import pov_stc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slice_o) && $stable(columns_o))
    else $error("stalled result changed");

  // write and ignored requests leave the block ready
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_WRITE || mode_i == MODE_NONE) |=> in_ready_o)
    else $error("write request did not finish in one cycle");

  // a tick request keeps the block busy
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == MODE_TICK |=> !in_ready_o)
    else $error("tick request did not occupy the block");

  // a new result appears only as the block goes idle
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while busy");

endmodule

bind pov_slice_timing_controller pov_stc_chk u_chk (.*);

@@ tb/pov_slice_timing_checker.sv @@
`timescale 1ns / 1ps

module pov_slice_timing_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [pov_stc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pov_stc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [pov_stc_pkg::MODE_W-1:0]        mode_i,
  input  logic [pov_stc_pkg::ADDR_W-1:0]        slice_addr_i,
  input  logic [pov_stc_pkg::LED_COUNT-1:0]     pattern_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic [pov_stc_pkg::SLICE_W-1:0]       slice_i,
  input  logic [pov_stc_pkg::LED_COUNT-1:0]     columns_i,
  output int                                    fail_count_o,
  output int                                    pending_o,
  output int                                    checked_o
);

  import pov_stc_pkg::*;

  localparam int unsigned NUM_SLICES = SLICES_DEF;

  typedef struct packed {
    logic [SLICE_W-1:0]   slice;
    logic [LED_COUNT-1:0] columns;
  } column_out_t;

  logic [HOLDOFF_W-1:0] holdoff_q;
  logic [SCALE_W-1:0]   scale_q;
  logic [CNT_W-1:0]     elapsed_q;
  logic [CNT_W-1:0]     period_q;
  logic [5:0]           shown_q;
  logic                 shown_vld_q;
  logic [LED_COUNT-1:0] column_table [NUM_SLICES];
  column_out_t          due_columns_q [$];
  int                   error_count;
  int                   result_count;

  // slices * elapsed * scale / period, clamped to the last slice
  function automatic logic [5:0] angular_slice(input logic [CNT_W-1:0] elapsed,
                                               input logic [CNT_W-1:0] period,
                                               input logic [SCALE_W-1:0] scale);
    logic [63:0] num;
    logic [63:0] quo;
    if (period == '0) return 6'(NUM_SLICES - 1);
    num = 64'(NUM_SLICES) * 64'(elapsed) * 64'(scale);
    quo = num / 64'(period);
    if (quo > 64'(NUM_SLICES - 1)) quo = 64'(NUM_SLICES - 1);
    return quo[5:0];
  endfunction

  function automatic void advance_display(input logic [MODE_W-1:0]    mode,
                                          input logic [ADDR_W-1:0]    addr,
                                          input logic [LED_COUNT-1:0] pat);
    logic [63:0] avg;
    logic [5:0]  now;
    column_out_t res;
    case (mode)
      MODE_WRITE: begin
        column_table[addr] = pat;
        return;
      end
      MODE_TICK: begin
        if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
      end
      MODE_EDGE: begin
        if (elapsed_q > holdoff_q) begin
          avg = (64'(period_q) + 64'(elapsed_q) * 64'(scale_q)) >> 1;
          if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
          period_q  = avg[CNT_W-1:0];
          elapsed_q = '0;
        end
      end
      default: return;
    endcase
    now = angular_slice(elapsed_q, period_q, scale_q);
    if (shown_vld_q && now == shown_q) return;
    shown_vld_q = 1'b1;
    shown_q     = now;
    res.slice   = now[SLICE_W-1:0];
    res.columns = column_table[now[SLICE_W-1:0]];
    due_columns_q.push_back(res);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q     = HOLDOFF_RST;
      scale_q       = SCALE_RST;
      elapsed_q     = 1;
      period_q      = 1;
      shown_q       = 6'd33;
      shown_vld_q   = 1'b0;
      error_count   = 0;
      result_count  = 0;
      due_columns_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin : watch
      column_out_t due;
      // results first: a result never stems from a request taken at the same edge
      if (out_valid_i && out_ready_i) begin
        result_count++;
        if (due_columns_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none actual slice %0d columns %04h",
                   $time, slice_i, columns_i);
        end else begin
          due = due_columns_q.pop_front();
          if (slice_i !== due.slice) begin
            error_count++;
            $display("%0t: slice mismatch, expected %0d actual %0d",
                     $time, due.slice, slice_i);
          end
          if (columns_i !== due.columns) begin
            error_count++;
            $display("%0t: columns mismatch, expected %04h actual %04h",
                     $time, due.columns, columns_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_HOLDOFF: holdoff_q = cfg_data_i[HOLDOFF_W-1:0];
          REG_SCALE:   scale_q   = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) advance_display(mode_i, slice_addr_i, pattern_i);
      fail_count_o <= error_count;
      pending_o    <= due_columns_q.size();
      checked_o    <= result_count;
    end
  end

endmodule

@@ tb/tb_pov_slice_timing_controller.sv @@
`timescale 1ns / 1ps

module tb_pov_slice_timing_controller;

  import pov_stc_pkg::*;

  // stimulus sizing and timing
  localparam int unsigned ITEM_TARGET   = 850;
  localparam int unsigned SETTLE_CYCLES = 40;        // margin for a result-less divide to run out
  localparam longint      RUN_LIMIT_NS  = 2_000_000; // watchdog limit on simulated time

  // codes the package leaves unnamed
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [MODE_W-1:0]     mode_i       = '0;
  logic [ADDR_W-1:0]     slice_addr_i = '0;
  logic [LED_COUNT-1:0]  pattern_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [SLICE_W-1:0]    slice_o;
  logic [LED_COUNT-1:0]  columns_o;

  int fail_count;
  int pending_results;
  int results_checked;

  // run bookkeeping for the summary
  int requests_sent  = 0;
  int register_writes = 0;
  int phases_run     = 0;

  // when set, neither side idles: back-to-back requests and an always-ready receiver
  bit quiet = 1'b0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  pov_slice_timing_controller u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .slice_addr_i (slice_addr_i),
    .pattern_i    (pattern_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slice_o      (slice_o),
    .columns_o    (columns_o)
  );

  // prediction and comparison live beside the block
  pov_slice_timing_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .slice_addr_i (slice_addr_i),
    .pattern_i    (pattern_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slice_i      (slice_o),
    .columns_i    (columns_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .checked_o    (results_checked)
  );

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request on the input channel; returns at the edge that accepts it
  task automatic send_request(input logic [MODE_W-1:0]    mode,
                              input logic [ADDR_W-1:0]    addr,
                              input logic [LED_COUNT-1:0] pat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    slice_addr_i <= addr;
    pattern_i    <= pat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // mode 3 is dropped by the block, so it does not count as real work
    if (mode != MODE_NONE) requests_sent++;
  endtask

  // tick or edge with junk in the fields the block ignores for them
  task automatic send_rotation(input logic [MODE_W-1:0] mode);
    send_request(mode, ADDR_W'($urandom), LED_COUNT'($urandom));
  endtask

  // keeps cfg_valid_i high; the caller lowers it after the last write
  task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    register_writes++;
  endtask

  // drain every due result, then let a result-less divide run out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] holdoff,
                             input logic [CFG_DATA_W-1:0] scale,
                             input bit                    with_spare);
    wait_idle();
    write_register(REG_HOLDOFF, holdoff);
    write_register(REG_SCALE, scale);
    // writes to unused indexes must change nothing
    if (with_spare || $urandom_range(0, 3) == 0) begin
      write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                     CFG_DATA_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // receiver side: ready stretches broken by stalls of random length
  initial begin : result_stall
    int n;
    @(posedge clk_i);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int                    cls;
    int                    rotations;
    int                    span;
    int                    len;
    int                    sel;
    logic [CFG_DATA_W-1:0] holdoff;
    logic [CFG_DATA_W-1:0] scale;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole column table first so no unwritten entry is ever shown;
    // the first entries carry the pattern extremes
    for (int a = 0; a < int'(SLICES_DEF); a++) begin
      case (a)
        0:       send_request(MODE_WRITE, ADDR_W'(a), 16'h0000);
        1:       send_request(MODE_WRITE, ADDR_W'(a), 16'hFFFF);
        2:       send_request(MODE_WRITE, ADDR_W'(a), 16'hAAAA);
        3:       send_request(MODE_WRITE, ADDR_W'(a), 16'h5555);
        default: send_request(MODE_WRITE, ADDR_W'(a), LED_COUNT'($urandom));
      endcase
    end

    // directed: reset settings, first display goes out on the very first tick
    send_rotation(MODE_TICK);
    send_rotation(MODE_TICK);                   // same slice, nothing shown
    send_request(MODE_NONE, 5'd31, 16'hFFFF);   // unknown mode is ignored
    send_rotation(MODE_EDGE);                   // count below holdoff, edge dropped

    // no holdoff, unit scale: edges take and the slice walks
    reconfigure(16'd0, 16'd1, 1'b1);
    send_rotation(MODE_EDGE);
    send_rotation(MODE_TICK);
    send_rotation(MODE_TICK);
    send_rotation(MODE_EDGE);

    // zero scale: the period halves down to zero, slice forced to the last one
    reconfigure(16'd0, 16'd0, 1'b0);
    send_rotation(MODE_TICK);
    send_rotation(MODE_EDGE);
    send_rotation(MODE_TICK);
    send_rotation(MODE_EDGE);
    send_rotation(MODE_TICK);

    // largest holdoff: every edge is dropped
    reconfigure(16'hFFFF, 16'd255, 1'b0);
    send_rotation(MODE_TICK);
    send_rotation(MODE_EDGE);

    // recover from the zero period with full scale
    reconfigure(16'd0, 16'hFF00 | 16'd255, 1'b0);
    send_rotation(MODE_TICK);
    send_rotation(MODE_EDGE);
    send_rotation(MODE_TICK);

    // random phases: steady rotations with random content, noise between ticks
    while (requests_sent < int'(ITEM_TARGET)) begin
      cls = $urandom_range(0, 5);
      case (cls)
        0: begin
          holdoff = 16'd0;
          scale   = 16'd1;
        end
        1: begin
          holdoff = CFG_DATA_W'($urandom_range(0, 8));
          scale   = 16'd255;
        end
        2: begin
          holdoff = CFG_DATA_W'($urandom_range(0, 15));
          scale   = CFG_DATA_W'($urandom_range(1, 255));
        end
        3: begin
          // zero scale hidden under junk in the unused upper data bits
          holdoff = CFG_DATA_W'($urandom_range(0, 15));
          scale   = {8'($urandom), 8'h00};
        end
        4: begin
          holdoff = 16'hFFFF;
          scale   = CFG_DATA_W'($urandom_range(1, 255));
        end
        default: begin
          holdoff = CFG_DATA_W'($urandom);
          scale   = CFG_DATA_W'($urandom);
        end
      endcase
      reconfigure(holdoff, scale, 1'b0);
      quiet      = ($urandom_range(0, 4) == 0);
      phases_run++;
      // phases where edges rarely take or the slice stays put are kept short
      rotations = (cls >= 3) ? 1 : $urandom_range(2, 4);
      span      = $urandom_range(16, 64);
      for (int r = 0; r < rotations; r++) begin
        len = span + $urandom_range(0, 6) - 3;
        for (int k = 0; k < len; k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 6) send_request(MODE_WRITE, ADDR_W'($urandom), LED_COUNT'($urandom));
          else if (sel < 8) send_request(MODE_NONE, ADDR_W'($urandom), LED_COUNT'($urandom));
          else if (sel < 10) send_rotation(MODE_EDGE);   // stray edge mid-rotation
          send_rotation(MODE_TICK);
        end
        send_rotation(MODE_EDGE);
      end
    end

    quiet = 1'b0;
    wait_idle();

    $display("covered %0d requests in %0d random phases and %0d register writes",
             requests_sent, phases_run, register_writes);
    $display("compared %0d displayed slices against the prediction", results_checked);
    if (fail_count == 0) begin
      $display("tb_pov_slice_timing_controller: PASS");
    end else begin
      $display("tb_pov_slice_timing_controller: FAIL");
    end
    $finish;
  end

  // hung handshake or results that never arrive
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results still due", pending_results);
    $display("tb_pov_slice_timing_controller: FAIL");
    $finish;
  end

endmodule
